### src/eic_pkg.sv
package eic_pkg;

  // item kinds carried on in_tuser
  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // register select (paddr bit 2)
  localparam logic REG_GLITCH = 1'b0;
  localparam logic REG_RADIO  = 1'b1;

  localparam logic [15:0] GLITCH_RESET = 16'd50;

  localparam int TS_W    = 32;
  localparam int RIDX_W  = 10;
  localparam int COUNT_W = 11;
  localparam int THR_W   = 16;

  // status of one item, passed from the control stage to the output register
  typedef struct packed {
    logic               edge_stored;
    logic [COUNT_W-1:0] entry_count;
    logic               recording_on;
    logic               read_valid;
  } eic_info_t;

  // one stored entry
  typedef struct packed {
    logic            level;
    logic [TS_W-1:0] duration;
  } eic_entry_t;

endpackage

### src/eic_mem.sv
module eic_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  eic_pkg::eic_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output eic_pkg::eic_entry_t rd_data
);

  eic_pkg::eic_entry_t mem [DEPTH];
  eic_pkg::eic_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/eic_ctrl.sv
module eic_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [eic_pkg::TS_W-1:0]        ts,
  input  logic                            lvl,
  input  logic [eic_pkg::RIDX_W-1:0]      ridx,
  input  logic [eic_pkg::THR_W-1:0]       glitch_thr,
  input  logic                            radio_present,
  input  logic                            s1_advance,
  output logic                            s1_valid,
  output eic_pkg::eic_info_t              s1_info,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output eic_pkg::eic_entry_t             wr_data,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr
);

  localparam int CMPW = (CW > eic_pkg::RIDX_W) ? CW : eic_pkg::RIDX_W;
  localparam int EW   = (CW > eic_pkg::COUNT_W) ? CW : eic_pkg::COUNT_W;

  logic                       recording_r, recording_nxt;
  logic [eic_pkg::TS_W-1:0]   last_r, last_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       s1_valid_r;
  eic_pkg::eic_info_t         s1_info_r, info_nxt;

  logic                       fire;
  logic [eic_pkg::TS_W-1:0]   diff;
  logic                       keep;
  logic                       not_full;
  logic [CMPW-1:0]            ridx_w;
  logic [CMPW-1:0]            count_w;
  logic [EW-1:0]              count_e;

  assign in_ready = !s1_valid_r || s1_advance;
  assign fire     = in_valid && in_ready;

  assign diff     = ts - last_r;
  assign keep     = diff >= eic_pkg::TS_W'(glitch_thr);
  assign not_full = count_r < CW'(DEPTH);
  assign ridx_w   = CMPW'(ridx);
  assign count_w  = CMPW'(count_r);

  // store on a kept edge while recording and not full
  assign wr_en   = fire && (op == eic_pkg::OP_EDGE) && recording_r && keep && not_full;
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = '{level: lvl, duration: diff};

  // read the entry now; data arrives with the item in the next stage
  assign rd_en   = fire && (op == eic_pkg::OP_READ);
  assign rd_addr = ridx_w[AW-1:0];

  // update capture state for the accepted item
  always_comb begin
    recording_nxt = recording_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    info_nxt      = '0;
    case (op)
      eic_pkg::OP_EDGE: begin
        if (recording_r) begin
          last_nxt = ts;
          if (keep && not_full) begin
            count_nxt            = count_r + CW'(1);
            info_nxt.edge_stored = 1'b1;
          end
        end
      end
      eic_pkg::OP_START: begin
        if (radio_present) begin
          count_nxt     = '0;
          last_nxt      = ts;
          recording_nxt = 1'b1;
        end
      end
      eic_pkg::OP_STOP: begin
        recording_nxt = 1'b0;
      end
      eic_pkg::OP_READ: begin
        info_nxt.read_valid = (ridx_w < count_w) && (ridx_w < CMPW'(DEPTH));
      end
      default: begin
        recording_nxt = recording_r;
      end
    endcase
    count_e               = EW'(count_nxt);
    info_nxt.entry_count  = count_e[eic_pkg::COUNT_W-1:0];
    info_nxt.recording_on = recording_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recording_r <= 1'b0;
      last_r      <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        recording_r <= recording_nxt;
        last_r      <= last_nxt;
        count_r     <= count_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  // hold item status alongside the memory read
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_info_r <= info_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_info  = s1_info_r;

endmodule

### src/edge_interval_capture_top.sv
// Edge interval capture: takes one item per clock (edge, start, stop or read,
// kind on in_tuser) and returns exactly one result item per input item, via
// the control and output registers. Captured intervals and line levels live in
// one synchronous BUFFER_DEPTH-entry memory; the single write port serves edge
// items and the single registered read port serves read items, so a read may
// directly follow the write of the same entry. Sustained rate is one item per
// cycle while out_tready stays high. Entries above the current count are never
// returned; there is no clearing pass after reset.
module edge_interval_capture_top #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] timestamp_us, [32] line_level, [42:33] read_index, [47:43] zero
  input  logic [47:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] edge_stored, [11:1] entry_count, [12] recording_on, [13] read_valid,
  // [45:14] read_duration_us, [46] read_level, [47] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [eic_pkg::THR_W-1:0] glitch_r;
  logic                      radio_r;
  logic                      cfg_wr;

  logic                      s1_advance;
  logic                      s1_valid;
  eic_pkg::eic_info_t        s1_info;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  eic_pkg::eic_entry_t       wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  eic_pkg::eic_entry_t       rd_data;

  logic                      out_valid_r;
  logic [47:0]               out_data_r, out_data_nxt;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_r <= eic_pkg::GLITCH_RESET;
      radio_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        eic_pkg::REG_GLITCH: glitch_r <= cfg_pwdata[eic_pkg::THR_W-1:0];
        eic_pkg::REG_RADIO:  radio_r  <= cfg_pwdata[0];
        default:             radio_r  <= radio_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      eic_pkg::REG_GLITCH: cfg_prdata = 32'(glitch_r);
      eic_pkg::REG_RADIO:  cfg_prdata = 32'(radio_r);
      default:             cfg_prdata = '0;
    endcase
  end

  eic_ctrl #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .op            (in_tuser),
    .ts            (in_tdata[31:0]),
    .lvl           (in_tdata[32]),
    .ridx          (in_tdata[42:33]),
    .glitch_thr    (glitch_r),
    .radio_present (radio_r),
    .s1_advance    (s1_advance),
    .s1_valid      (s1_valid),
    .s1_info       (s1_info),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr)
  );

  eic_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: advance when empty or taken
  assign s1_advance = !out_valid_r || out_tready;

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[0]     = s1_info.edge_stored;
    out_data_nxt[11:1]  = s1_info.entry_count;
    out_data_nxt[12]    = s1_info.recording_on;
    out_data_nxt[13]    = s1_info.read_valid;
    if (s1_info.read_valid) begin
      out_data_nxt[45:14] = rd_data.duration;
      out_data_nxt[46]    = rd_data.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/eic_checker.sv
module eic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // read fields stay zero unless the read hit a stored entry
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[13] |-> out_tdata[46:14] == 33'd0)
    else $error("read data on result without valid read");

  // a stored edge happens only while recording, and never with a read
  a_store_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[12] && !out_tdata[13])
    else $error("edge stored while not recording or on a read");

endmodule

bind edge_interval_capture_top eic_checker u_eic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
